// ----- rtl/core/gpm_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gpm_pkg
// Types, codes and constants shared by the gamepad event mapper modules.
// ----------------------------------------------------------------------------
package gpm_pkg;

    localparam int ENTRIES  = 16;
    localparam int IDX_W    = $clog2(ENTRIES);
    localparam int CNT_W    = $clog2(ENTRIES + 1);
    localparam int ENTRY_W  = 100;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_EVENT  = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;

    localparam logic [1:0] KIND_BUTTON = 2'd0;
    localparam logic [1:0] KIND_STATUS = 2'd1;
    localparam logic [1:0] KIND_QUERY  = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_ORDER = 2'd2;

    localparam logic [3:0] TGT_HAT   = 4'd8;
    localparam logic [2:0] BTN_UP    = 3'd4;
    localparam logic [2:0] BTN_DOWN  = 3'd5;
    localparam logic [2:0] BTN_LEFT  = 3'd6;
    localparam logic [2:0] BTN_RIGHT = 3'd7;
    localparam logic [7:0] FULL_MASK = 8'hff;

    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [31:0] src_id;
        logic signed [31:0] src_value;
        logic signed [31:0] range_low;
        logic signed [31:0] range_high;
        logic [3:0]         target;
        logic [4:0]         position;
        logic               auto_position;
    } req_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [2:0] button;
        logic       level;
        logic [1:0] status;
        logic       suitable;
        logic       last;
    } rsp_t;

    typedef struct packed {
        logic signed [31:0] src;
        logic signed [31:0] low;
        logic signed [31:0] high;
        logic [3:0]         target;
    } entry_t;

    // controller -> datapath
    typedef struct packed {
        logic             load;     // latch request
        logic             rd_en;    // read entry at rd_addr
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        logic             wr_new;   // write request entry, else read data
        logic             cnt_inc;
        logic             mask_clr;
        logic             mask_acc; // fold read entry into coverage mask
        logic             emit;
        rsp_t             rsp;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [1:0]       cmd;
        logic             auto_pos;
        logic [4:0]       position;
        logic [CNT_W-1:0] count;
        logic             rd_lt;    // read id < request id
        logic             rd_gt;    // read id > request id
        logic             rd_hat;
        logic [2:0]       rd_btn;
        logic             rd_lvl;
        logic signed [1:0] hat_x;
        logic signed [1:0] hat_y;
        logic             covered;
    } dp_sts_t;

endpackage
`default_nettype wire

// ----- rtl/core/gpm_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gpm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule
`default_nettype wire

// ----- rtl/core/gpm_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gpm_datapath
// Request register, entry table, compares, hat decode, coverage mask, output.
// ----------------------------------------------------------------------------
module gpm_datapath
    import gpm_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire req_t    req_in,
    input  wire dp_cmd_t cmd,
    output dp_sts_t      sts,
    output logic         done,
    output rsp_t         result
);
    req_t             req_reg;
    logic [CNT_W-1:0] count_reg;
    logic [7:0]       mask_reg;
    logic             done_reg;
    rsp_t             result_reg;
    entry_t           rd_ent;
    entry_t           wr_ent;
    logic [31:0]      diff;

    assign wr_ent = cmd.wr_new ? entry_t'{req_reg.src_id, req_reg.range_low,
                                          req_reg.range_high, req_reg.target}
                               : rd_ent;

    gpm_ram #(.WIDTH(ENTRY_W), .DEPTH(ENTRIES)) u_tab (
        .clk     (clk),
        .wr_en   (cmd.wr_en),
        .wr_addr (cmd.wr_addr),
        .wr_data (wr_ent),
        .rd_en   (cmd.rd_en),
        .rd_addr (cmd.rd_addr),
        .rd_data (rd_ent)
    );

    assign diff = req_reg.src_value - rd_ent.low;

    always_comb
    begin
        sts.cmd      = req_reg.cmd;
        sts.auto_pos = req_reg.auto_position;
        sts.position = req_reg.position;
        sts.count    = count_reg;
        sts.rd_lt    = rd_ent.src < req_reg.src_id;
        sts.rd_gt    = rd_ent.src > req_reg.src_id;
        sts.rd_hat   = rd_ent.target >= TGT_HAT;
        sts.rd_btn   = rd_ent.target[2:0];
        sts.rd_lvl   = (req_reg.src_value >= rd_ent.low) &&
                       (req_reg.src_value <= rd_ent.high);
        sts.hat_x    = 2'sd0;
        sts.hat_y    = 2'sd0;
        case (diff)
            32'd0: sts.hat_y = -2'sd1;
            32'd1: begin sts.hat_x = 2'sd1;  sts.hat_y = -2'sd1; end
            32'd2: sts.hat_x = 2'sd1;
            32'd3: begin sts.hat_x = 2'sd1;  sts.hat_y = 2'sd1;  end
            32'd4: sts.hat_y = 2'sd1;
            32'd5: begin sts.hat_x = -2'sd1; sts.hat_y = 2'sd1;  end
            32'd6: sts.hat_x = -2'sd1;
            32'd7: begin sts.hat_x = -2'sd1; sts.hat_y = -2'sd1; end
            default: ;
        endcase
        sts.covered  = mask_reg == FULL_MASK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            mask_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.emit;
            if (cmd.cnt_inc)
            begin
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.mask_clr)
            begin
                mask_reg <= '0;
            end
            else if (cmd.mask_acc)
            begin
                if (sts.rd_hat)
                begin
                    mask_reg <= mask_reg | 8'hf0;
                end
                else
                begin
                    mask_reg <= mask_reg | (8'd1 << rd_ent.target[2:0]);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req_in;
        end
        if (cmd.emit)
        begin
            result_reg <= cmd.rsp;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;
endmodule
`default_nettype wire

// ----- rtl/core/gpm_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gpm_ctrl
// Sequencer: lower-bound search, order check, shift-insert, event walk, query.
// ----------------------------------------------------------------------------
module gpm_ctrl
    import gpm_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    start,
    input  wire dp_sts_t sts,
    output logic         busy,
    output dp_cmd_t      cmd
);
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DISP   = 4'd1;
    localparam logic [3:0] S_SRCH   = 4'd2;  // read issued at idx
    localparam logic [3:0] S_CHKA   = 4'd3;  // read p-1 issued
    localparam logic [3:0] S_CHKB   = 4'd4;  // read p issued
    localparam logic [3:0] S_SHIFT  = 4'd5;  // read idx-1 issued, write idx
    localparam logic [3:0] S_EVT    = 4'd6;  // read idx issued
    localparam logic [3:0] S_HAT    = 4'd7;
    localparam logic [3:0] S_QRY    = 4'd8;
    localparam logic [3:0] S_QEND   = 4'd9;
    localparam logic [3:0] S_FINI   = 4'd10;

    logic [3:0]       state_reg, state_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] pos_reg, pos_next;
    logic [1:0]       hs_reg, hs_next;    // hat result step
    logic [1:0]       st_reg, st_next;
    // button result held back until the next entry shows whether it is last
    logic             pend_reg, pend_next;
    logic [2:0]       pbtn_reg, pbtn_next;
    logic             plvl_reg, plvl_next;
    logic signed [1:0] hx_reg, hx_next, hy_reg, hy_next;
    logic [CNT_W-1:0] idx_inc;
    logic             tail;

    assign busy    = state_reg != S_IDLE;
    assign idx_inc = idx_reg + 1'b1;

    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        pos_next     = pos_reg;
        hs_next      = hs_reg;
        st_next      = st_reg;
        pend_next    = pend_reg;
        pbtn_next    = pbtn_reg;
        plvl_next    = plvl_reg;
        hx_next      = hx_reg;
        hy_next      = hy_reg;
        tail         = 1'b0;
        cmd          = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                idx_next  = '0;
                pend_next = 1'b0;
                case (sts.cmd)
                    CMD_INSERT, CMD_EVENT:
                    begin
                        if (sts.count == '0)
                        begin
                            pos_next = '0;
                            if (sts.cmd == CMD_INSERT)
                            begin
                                state_next = S_CHKA;
                            end
                            else
                            begin
                                state_next = S_IDLE;
                            end
                        end
                        else if (sts.cmd == CMD_INSERT && !sts.auto_pos &&
                                 {1'b0, sts.position} <= 6'(sts.count))
                        begin
                            pos_next = sts.position[CNT_W-1:0];
                            state_next = S_CHKA;
                        end
                        else
                        begin
                            cmd.rd_en   = 1'b1;
                            cmd.rd_addr = '0;
                            state_next  = S_SRCH;
                        end
                    end
                    CMD_QUERY:
                    begin
                        cmd.mask_clr = 1'b1;
                        if (sts.count == '0)
                        begin
                            state_next = S_QEND;
                        end
                        else
                        begin
                            cmd.rd_en   = 1'b1;
                            cmd.rd_addr = '0;
                            state_next  = S_QRY;
                        end
                    end
                    default: state_next = S_IDLE;
                endcase
            end
            S_SRCH:
            begin
                if (sts.rd_lt && idx_inc < sts.count)
                begin
                    idx_next    = idx_inc;
                    cmd.rd_en   = 1'b1;
                    cmd.rd_addr = idx_inc[IDX_W-1:0];
                end
                else
                begin
                    pos_next = sts.rd_lt ? idx_inc : idx_reg;
                    if (sts.cmd == CMD_EVENT)
                    begin
                        // flush the held result; it is last when the walk ends
                        if (pend_reg)
                        begin
                            cmd.emit       = 1'b1;
                            cmd.rsp.kind   = KIND_BUTTON;
                            cmd.rsp.button = pbtn_reg;
                            cmd.rsp.level  = plvl_reg;
                            cmd.rsp.last   = sts.rd_lt || sts.rd_gt;
                        end
                        pend_next = 1'b0;
                        if (sts.rd_lt || sts.rd_gt)
                        begin
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            // entry at idx already read and matches
                            state_next = S_EVT;
                        end
                    end
                    else
                    begin
                        state_next = S_CHKA;
                    end
                end
                if (sts.cmd == CMD_INSERT && state_next == S_CHKA)
                begin
                    pos_next = sts.rd_lt ? idx_inc : idx_reg;
                end
            end
            S_CHKA:
            begin
                // Issue read of p-1 (if any); checked in S_CHKB
                if (pos_reg != '0)
                begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_addr = IDX_W'(pos_reg - 1'b1);
                end
                idx_next   = '0;
                state_next = S_CHKB;
            end
            S_CHKB:
            begin
                if (idx_reg == '0)
                begin
                    if (pos_reg != '0 && sts.rd_gt)
                    begin
                        st_next    = ST_ORDER;
                        state_next = S_FINI;
                    end
                    else
                    begin
                        idx_next = CNT_W'(1);
                        if (pos_reg < sts.count)
                        begin
                            cmd.rd_en   = 1'b1;
                            cmd.rd_addr = pos_reg[IDX_W-1:0];
                        end
                    end
                end
                else
                begin
                    if (pos_reg < sts.count && sts.rd_lt)
                    begin
                        st_next    = ST_ORDER;
                        state_next = S_FINI;
                    end
                    else if (32'(sts.count) >= 32'(ENTRIES))
                    begin
                        st_next    = ST_FULL;
                        state_next = S_FINI;
                    end
                    else
                    begin
                        idx_next = sts.count;
                        if (sts.count != pos_reg)
                        begin
                            cmd.rd_en   = 1'b1;
                            cmd.rd_addr = IDX_W'(sts.count - 1'b1);
                        end
                        state_next = S_SHIFT;
                    end
                end
            end
            S_SHIFT:
            begin
                cmd.wr_en   = 1'b1;
                cmd.wr_addr = idx_reg[IDX_W-1:0];
                if (idx_reg == pos_reg)
                begin
                    cmd.wr_new  = 1'b1;
                    cmd.cnt_inc = 1'b1;
                    st_next     = ST_OK;
                    state_next  = S_FINI;
                end
                else
                begin
                    idx_next = idx_reg - 1'b1;
                    if (idx_reg - 1'b1 != pos_reg)
                    begin
                        cmd.rd_en   = 1'b1;
                        cmd.rd_addr = IDX_W'(idx_reg - 2'd2);
                    end
                end
            end
            S_FINI:
            begin
                cmd.emit       = 1'b1;
                cmd.rsp.kind   = KIND_STATUS;
                cmd.rsp.status = st_reg;
                cmd.rsp.last   = 1'b1;
                state_next     = S_IDLE;
            end
            S_EVT:
            begin
                tail = !(idx_inc < sts.count);
                if (sts.rd_hat)
                begin
                    hx_next    = sts.hat_x;
                    hy_next    = sts.hat_y;
                    hs_next    = 2'd0;
                    state_next = S_HAT;
                end
                else
                begin
                    if (tail)
                    begin
                        cmd.emit       = 1'b1;
                        cmd.rsp.kind   = KIND_BUTTON;
                        cmd.rsp.button = sts.rd_btn;
                        cmd.rsp.level  = sts.rd_lvl;
                        cmd.rsp.last   = 1'b1;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        pend_next   = 1'b1;
                        pbtn_next   = sts.rd_btn;
                        plvl_next   = sts.rd_lvl;
                        idx_next    = idx_inc;
                        cmd.rd_en   = 1'b1;
                        cmd.rd_addr = idx_inc[IDX_W-1:0];
                        state_next  = S_SRCH;
                    end
                end
            end
            S_HAT:
            begin
                // four results: release x, release y, press x, press y;
                // with x or y zero both directions are released and no press
                cmd.emit     = 1'b1;
                cmd.rsp.kind = KIND_BUTTON;
                tail         = !(idx_inc < sts.count);
                case (hs_reg)
                    2'd0: cmd.rsp.button = (hx_reg >= 0) ? BTN_LEFT : BTN_RIGHT;
                    2'd1:
                    begin
                        if (hx_reg == 0)
                        begin
                            cmd.rsp.button = BTN_RIGHT;
                        end
                        else
                        begin
                            cmd.rsp.button = (hy_reg >= 0) ? BTN_UP : BTN_DOWN;
                        end
                    end
                    2'd2:
                    begin
                        if (hx_reg == 0)
                        begin
                            cmd.rsp.button = (hy_reg >= 0) ? BTN_UP : BTN_DOWN;
                        end
                        else if (hy_reg == 0)
                        begin
                            cmd.rsp.button = BTN_DOWN;
                        end
                        else
                        begin
                            cmd.rsp.button = (hx_reg < 0) ? BTN_LEFT : BTN_RIGHT;
                            cmd.rsp.level  = 1'b1;
                        end
                    end
                    default:
                    begin
                        if (hx_reg == 0 && hy_reg == 0)
                        begin
                            cmd.rsp.button = BTN_DOWN;
                        end
                        else if (hx_reg == 0)
                        begin
                            cmd.rsp.button = (hy_reg < 0) ? BTN_UP : BTN_DOWN;
                            cmd.rsp.level  = 1'b1;
                        end
                        else if (hy_reg == 0)
                        begin
                            cmd.rsp.button = (hx_reg < 0) ? BTN_LEFT : BTN_RIGHT;
                            cmd.rsp.level  = 1'b1;
                        end
                        else
                        begin
                            cmd.rsp.button = (hy_reg < 0) ? BTN_UP : BTN_DOWN;
                            cmd.rsp.level  = 1'b1;
                        end
                    end
                endcase
                hs_next = hs_reg + 1'b1;
                if (hs_reg == 2'd3)
                begin
                    if (tail)
                    begin
                        cmd.rsp.last = 1'b1;
                        state_next   = S_IDLE;
                    end
                    else
                    begin
                        cmd.emit    = 1'b0;
                        pend_next   = 1'b1;
                        pbtn_next   = cmd.rsp.button;
                        plvl_next   = cmd.rsp.level;
                        idx_next    = idx_inc;
                        cmd.rd_en   = 1'b1;
                        cmd.rd_addr = idx_inc[IDX_W-1:0];
                        state_next  = S_SRCH;
                    end
                end
            end
            S_QRY:
            begin
                cmd.mask_acc = 1'b1;
                if (idx_inc < sts.count)
                begin
                    idx_next    = idx_inc;
                    cmd.rd_en   = 1'b1;
                    cmd.rd_addr = idx_inc[IDX_W-1:0];
                end
                else
                begin
                    state_next = S_QEND;
                end
            end
            S_QEND:
            begin
                cmd.emit         = 1'b1;
                cmd.rsp.kind     = KIND_QUERY;
                cmd.rsp.suitable = sts.covered;
                cmd.rsp.last     = 1'b1;
                state_next       = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            pos_reg   <= '0;
            hs_reg    <= '0;
            st_reg    <= ST_OK;
            pend_reg  <= 1'b0;
            pbtn_reg  <= '0;
            plvl_reg  <= 1'b0;
            hx_reg    <= '0;
            hy_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            pos_reg   <= pos_next;
            hs_reg    <= hs_next;
            st_reg    <= st_next;
            pend_reg  <= pend_next;
            pbtn_reg  <= pbtn_next;
            plvl_reg  <= plvl_next;
            hx_reg    <= hx_next;
            hy_reg    <= hy_next;
        end
    end
endmodule
`default_nettype wire

// ----- rtl/core/gamepad_input_event_mapper_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gamepad_input_event_mapper_unit
// Sorted source-id mapping table with insert, event lookup and coverage query.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  request  | start / busy         | req (req_t)
//  result   | result_valid strobe  | result (rsp_t)
//
//  One request at a time; busy is high from acceptance until its last result.
//  Insert: search and order check, then a shift of the later entries and a
//  status. Event: search, then one result per matching button entry and four
//  per hat entry. Query: a walk over every stored entry. These walks use the
//  table RAM's single read port.
//  Reset empties the table. Results are strobed for one cycle and cannot be
//  stalled.
// ----------------------------------------------------------------------------
module gamepad_input_event_mapper_unit
    import gpm_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    input  wire req_t req,
    output logic      busy,
    output logic      result_valid,
    output rsp_t      result
);
    dp_cmd_t dp_cmd;
    dp_sts_t dp_sts;

    gpm_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (dp_sts),
        .busy  (busy),
        .cmd   (dp_cmd)
    );

    gpm_datapath u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .req_in (req),
        .cmd    (dp_cmd),
        .sts    (dp_sts),
        .done   (result_valid),
        .result (result)
    );
endmodule
`default_nettype wire

// ----- rtl/core/gpm_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gpm_checker
// Port-level checks for the event mapper, bound to the top level.
// ----------------------------------------------------------------------------
module gpm_checker
    import gpm_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic result_valid,
    input wire rsp_t result
);
    // an accepted request makes the unit busy
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy) else $error("busy not raised");

    // a result never appears the cycle after idle
    a_noidle: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |=> !result_valid) else $error("result while idle");

    // status and query results are always final
    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.kind == KIND_STATUS || result.kind == KIND_QUERY)
        |-> result.last) else $error("single result not last");

    // while a last result is shown the unit is already idle
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.last |-> !busy) else $error("busy after last");
endmodule

bind gamepad_input_event_mapper_unit gpm_checker u_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .result       (result)
);
`default_nettype wire

// ----- sim/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the gamepad event mapper: a table predictor built
// alongside the block produces expected results, a monitor compares them.
// ----------------------------------------------------------------------------
module testbench;
    import gpm_pkg::*;

    localparam int LIMIT = 400000;

    logic clk;
    logic rst_n;
    logic start;
    req_t req;
    logic busy;
    logic result_valid;
    rsp_t result;

    gamepad_input_event_mapper_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .req          (req),
        .busy         (busy),
        .result_valid (result_valid),
        .result       (result)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // predicted table
    entry_t     tbl [ENTRIES];
    int         tbl_count;
    rsp_t       expected_results [$];
    req_t       pending_reqs [$];
    int         errors;
    int         cycles;
    logic       stim_done;
    logic       drain_hold;
    int         gap;

    function automatic rsp_t mk(logic [1:0] k, logic [2:0] b, logic l,
                                logic [1:0] s, logic su);
        rsp_t r;
        r = '0;
        r.kind = k;
        r.button = b;
        r.level = l;
        r.status = s;
        r.suitable = su;
        return r;
    endfunction

    function automatic int first_not_below(logic signed [31:0] id);
        int i;
        i = 0;
        while (i < tbl_count && tbl[i].src < id)
            i++;
        return i;
    endfunction

    task automatic push_hat(logic signed [31:0] value, logic signed [31:0] base);
        logic [31:0] d;
        int x;
        int y;
        d = value - base;
        x = 0;
        y = 0;
        case (d)
            0: y = -1;
            1: begin x = 1; y = -1; end
            2: x = 1;
            3: begin x = 1; y = 1; end
            4: y = 1;
            5: begin x = -1; y = 1; end
            6: x = -1;
            7: begin x = -1; y = -1; end
            default: ;
        endcase
        if (x >= 0) expected_results.push_back(mk(KIND_BUTTON, BTN_LEFT, 0, ST_OK, 0));
        if (x <= 0) expected_results.push_back(mk(KIND_BUTTON, BTN_RIGHT, 0, ST_OK, 0));
        if (y >= 0) expected_results.push_back(mk(KIND_BUTTON, BTN_UP, 0, ST_OK, 0));
        if (y <= 0) expected_results.push_back(mk(KIND_BUTTON, BTN_DOWN, 0, ST_OK, 0));
        if (x < 0) expected_results.push_back(mk(KIND_BUTTON, BTN_LEFT, 1, ST_OK, 0));
        else if (x > 0) expected_results.push_back(mk(KIND_BUTTON, BTN_RIGHT, 1, ST_OK, 0));
        if (y < 0) expected_results.push_back(mk(KIND_BUTTON, BTN_UP, 1, ST_OK, 0));
        else if (y > 0) expected_results.push_back(mk(KIND_BUTTON, BTN_DOWN, 1, ST_OK, 0));
    endtask

    task automatic predict_mapping(req_t r);
        int n0;
        int p;
        int i;
        logic [1:0] st;
        logic [7:0] mask;
        n0 = expected_results.size();
        if (r.cmd == CMD_INSERT) begin
            p = r.position;
            if (r.auto_position || p > tbl_count)
                p = first_not_below(r.src_id);
            st = ST_OK;
            if (p > 0 && r.src_id < tbl[p-1].src)
                st = ST_ORDER;
            else if (p < tbl_count && r.src_id > tbl[p].src)
                st = ST_ORDER;
            else if (tbl_count >= ENTRIES)
                st = ST_FULL;
            else begin
                for (i = tbl_count; i > p; i--)
                    tbl[i] = tbl[i-1];
                tbl[p] = {r.src_id, r.range_low, r.range_high, r.target};
                tbl_count++;
            end
            expected_results.push_back(mk(KIND_STATUS, 0, 0, st, 0));
        end else if (r.cmd == CMD_EVENT) begin
            for (i = first_not_below(r.src_id); i < tbl_count; i++) begin
                if (tbl[i].src != r.src_id)
                    break;
                if (tbl[i].target >= TGT_HAT)
                    push_hat(r.src_value, tbl[i].low);
                else
                    expected_results.push_back(mk(KIND_BUTTON, tbl[i].target[2:0],
                        r.src_value >= tbl[i].low && r.src_value <= tbl[i].high,
                        ST_OK, 0));
            end
        end else if (r.cmd == CMD_QUERY) begin
            mask = '0;
            for (i = 0; i < tbl_count; i++)
                if (tbl[i].target >= TGT_HAT)
                    mask |= 8'hf0;
                else
                    mask[tbl[i].target[2:0]] = 1'b1;
            expected_results.push_back(mk(KIND_QUERY, 0, 0, ST_OK, mask == FULL_MASK));
        end
        if (expected_results.size() > n0)
            expected_results[expected_results.size()-1].last = 1'b1;
    endtask

    // driver
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            start <= 1'b0;
            req   <= '0;
            gap   <= 0;
        end else if (start && !busy) begin
            predict_mapping(req);
            start <= 1'b0;
            gap   <= $urandom_range(0, 9);
        end else if (!start) begin
            if (gap > 0)
                gap <= gap - 1;
            else if (pending_reqs.size() > 0 && !(drain_hold && expected_results.size() > 0)) begin
                req   <= pending_reqs.pop_front();
                start <= 1'b1;
            end
        end
    end

    // monitor
    always @(posedge clk) begin
        if (rst_n && result_valid) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result %p", result);
                errors++;
            end else begin
                rsp_t e;
                e = expected_results.pop_front();
                if (result.kind !== e.kind) begin
                    $error("kind exp %0d got %0d", e.kind, result.kind); errors++; end
                if (result.button !== e.button) begin
                    $error("button exp %0d got %0d", e.button, result.button); errors++; end
                if (result.level !== e.level) begin
                    $error("level exp %0d got %0d", e.level, result.level); errors++; end
                if (result.status !== e.status) begin
                    $error("status exp %0d got %0d", e.status, result.status); errors++; end
                if (result.suitable !== e.suitable) begin
                    $error("suitable exp %0d got %0d", e.suitable, result.suitable);
                    errors++;
                end
                if (result.last !== e.last) begin
                    $error("last exp %0d got %0d", e.last, result.last); errors++; end
            end
        end
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("gamepad_input_event_mapper_unit regression: fail");
            $finish;
        end
    end

    function automatic req_t mk_req(logic [1:0] c, logic [31:0] id, logic [31:0] v,
                                    logic [31:0] lo, logic [31:0] hi, logic [3:0] t,
                                    logic [4:0] p, logic a);
        req_t r;
        r = {c, id, v, lo, hi, t, p, a};
        return r;
    endfunction

    function automatic logic [31:0] rnd_id();
        case ($urandom_range(0, 3))
            0: return 32'h8000_0000 + $urandom_range(0, 3);
            1: return 32'h7fff_fffc + $urandom_range(0, 3);
            default: return $urandom_range(0, 7);
        endcase
    endfunction

    task automatic add_random(int n);
        int k;
        logic [31:0] id;
        logic [31:0] lo;
        for (k = 0; k < n; k++) begin
            id = rnd_id();
            lo = $urandom_range(0, 5) == 0 ? $urandom() : $urandom_range(0, 20) - 10;
            case ($urandom_range(0, 9))
                0, 1, 2: pending_reqs.push_back(mk_req(CMD_INSERT, id, $urandom(), lo,
                    $urandom_range(0, 5) == 0 ? $urandom() : lo + $urandom_range(0, 10),
                    $urandom_range(0, 15), $urandom_range(0, 31), $urandom_range(0, 1)));
                3, 4, 5, 6, 7: pending_reqs.push_back(mk_req(CMD_EVENT, id,
                    $urandom_range(0, 4) == 0 ? $urandom() : lo + $urandom_range(0, 10) - 1,
                    $urandom(), $urandom(), $urandom(), $urandom(), $urandom()));
                8: pending_reqs.push_back(mk_req(CMD_QUERY, $urandom(), $urandom(),
                    $urandom(), $urandom(), $urandom(), $urandom(), $urandom()));
                default: pending_reqs.push_back(mk_req(2'd3, $urandom(), $urandom(),
                    $urandom(), $urandom(), $urandom(), $urandom(), $urandom()));
            endcase
        end
    endtask

    initial begin
        int i;
        errors = 0;
        cycles = 0;
        tbl_count = 0;
        stim_done = 1'b0;
        drain_hold = 1'b0;
        rst_n = 1'b0;
        // directed: empty query/event, explicit positions, order breaks, hats
        pending_reqs.push_back(mk_req(CMD_QUERY, 0, 0, 0, 0, 0, 0, 0));
        pending_reqs.push_back(mk_req(CMD_EVENT, 5, 0, 0, 0, 0, 0, 0));
        pending_reqs.push_back(mk_req(CMD_INSERT, 5, 0, 32'h8000_0000, 32'h7fff_ffff, 0, 0, 0));
        pending_reqs.push_back(mk_req(CMD_INSERT, 3, 0, 0, 1, 1, 1, 0));
        pending_reqs.push_back(mk_req(CMD_INSERT, 3, 0, 0, 1, 1, 31, 0));
        pending_reqs.push_back(mk_req(CMD_INSERT, 32'h8000_0000, 0, 2, 9, 8, 0, 1));
        pending_reqs.push_back(mk_req(CMD_INSERT, 32'h7fff_ffff, 0, -3, 3, 15, 3, 0));
        for (i = 0; i < 9; i++)
            pending_reqs.push_back(mk_req(CMD_EVENT, 32'h8000_0000, 2 + i, 0, 0, 0, 0, 0));
        pending_reqs.push_back(mk_req(CMD_EVENT, 32'h7fff_ffff, 32'h8000_0000, 0, 0, 0, 0, 0));
        pending_reqs.push_back(mk_req(CMD_EVENT, 5, 32'h7fff_ffff, 0, 0, 0, 0, 0));
        pending_reqs.push_back(mk_req(CMD_EVENT, 3, 2, 0, 0, 0, 0, 0));
        for (i = 2; i < 8; i++)
            pending_reqs.push_back(mk_req(CMD_INSERT, 6, 0, 0, 0, i, 0, 1));
        pending_reqs.push_back(mk_req(CMD_QUERY, 0, 0, 0, 0, 0, 0, 0));
        pending_reqs.push_back(mk_req(2'd3, '1, '1, '1, '1, '1, '1, 1));
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        wait (pending_reqs.size() == 0);
        // let the queue drain once before random traffic
        drain_hold = 1'b1;
        add_random(1);
        wait (pending_reqs.size() == 0 && !start && !busy && expected_results.size() == 0);
        drain_hold = 1'b0;
        add_random(420);
        wait (pending_reqs.size() == 0);
        @(posedge clk);
        wait (!start && !busy && expected_results.size() == 0);
        repeat (50) @(posedge clk);
        if (errors == 0 && expected_results.size() == 0)
            $display("gamepad_input_event_mapper_unit regression: pass");
        else
            $display("gamepad_input_event_mapper_unit regression: fail");
        $finish;
    end
endmodule
